>>> design/jpeg_frame_header_scanner_defines.svh
// Assertion macros for the checker file of the frame header scanner.
`ifndef JPEG_FRAME_HEADER_SCANNER_DEFINES_SVH
`define JPEG_FRAME_HEADER_SCANNER_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define JFHS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jfhs assertion failed");

// Clocked assertion that also holds during reset.
`define JFHS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("jfhs assertion failed");

`endif

>>> design/jfhs_pkg.sv
package jfhs_pkg;

  localparam int unsigned PhaseW = 4;

  // Marker and header byte values.
  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] ByteSoi  = 8'hD8;
  localparam logic [7:0] ByteSof0 = 8'hC0;
  localparam logic [7:0] ByteSof2 = 8'hC2;
  localparam logic [15:0] LenSelf = 16'd2;

  localparam logic [7:0] NcompRgb  = 8'd3;
  localparam logic [7:0] NcompLuma = 8'd1;

  typedef enum logic [1:0] {
    FmtUnknown = 2'd0,
    FmtRgb8    = 2'd1,
    FmtLuma8   = 2'd2
  } pix_fmt_e;

  typedef struct packed {
    logic        header_ok;
    logic        frame_found;
    logic [15:0] image_width;
    logic [15:0] image_height;
    pix_fmt_e    pixel_format;
  } result_t;

endpackage

>>> design/jfhs_out_buf.sv
module jfhs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jfhs_pkg::result_t push_data_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output jfhs_pkg::result_t data_o
);
  import jfhs_pkg::*;

  // A result register with one skid entry behind it.
  logic    main_v_q, main_v_d;
  logic    skid_v_q, skid_v_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = main_v_q && ready_i;
  assign room_o  = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push_i;
        main_d   = push_data_i;
      end
    end else if (push_i) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = push_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

>>> design/jpeg_frame_header_scanner.sv
// Channel   | Direction | Handshake              | Beat payload
// ----------+-----------+------------------------+--------------------------------------
// input     | in        | in_valid_i/in_ready_o   | data_byte_i, stream_end_i
// result    | out       | out_valid_o/out_ready_i | header_ok_o, frame_found_o,
//           |           |                        | image_width_o, image_height_o,
//           |           |                        | pixel_format_o
//
// One input beat is taken per cycle while in_ready_o is high; the parser updates
// its phase and holds at the accepting edge, which also pushes any result into the output queue.
// The output has a result register plus one skid entry, so in_ready_o stays
// high while a single result waits; it drops only when two results are queued.
// Reset (rst_ni low, asynchronous) returns the parser to the first start-of-image
// byte and empties the output queue. No clearing pass is needed.
module jpeg_frame_header_scanner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 stream_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 header_ok_o,
  output logic                 frame_found_o,
  output logic [15:0]          image_width_o,
  output logic [15:0]          image_height_o,
  output logic [1:0]           pixel_format_o
);
  import jfhs_pkg::*;

  // Parse phases, in file order. Every phase from PhPrefix to PhNcomp means the
  // start-of-image marker was matched; PhDone also follows a bad one.
  localparam logic [PhaseW-1:0] PhSoi0   = 4'd0;
  localparam logic [PhaseW-1:0] PhSoi1   = 4'd1;
  localparam logic [PhaseW-1:0] PhPrefix = 4'd2;
  localparam logic [PhaseW-1:0] PhCode   = 4'd3;
  localparam logic [PhaseW-1:0] PhLenHi  = 4'd4;
  localparam logic [PhaseW-1:0] PhLenLo  = 4'd5;
  localparam logic [PhaseW-1:0] PhSkip   = 4'd6;
  localparam logic [PhaseW-1:0] PhPrec   = 4'd7;
  localparam logic [PhaseW-1:0] PhHHi    = 4'd8;
  localparam logic [PhaseW-1:0] PhHLo    = 4'd9;
  localparam logic [PhaseW-1:0] PhWHi    = 4'd10;
  localparam logic [PhaseW-1:0] PhWLo    = 4'd11;
  localparam logic [PhaseW-1:0] PhNcomp  = 4'd12;
  localparam logic [PhaseW-1:0] PhDone   = 4'd13;

  logic [PhaseW-1:0] phase_q, phase_d, phase_step;
  logic [15:0]       skip_q, skip_d;
  logic [7:0]        hi_q, hi_d;
  logic [15:0]       height_q, height_d;
  logic [15:0]       width_q, width_d;
  logic [7:0]        marker_q, marker_d;
  logic              sent_q, sent_d;

  logic              accept;
  logic              res_valid;
  result_t           res;
  logic              buf_room;
  result_t           out_data;

  logic [15:0]       seg_len;
  logic [15:0]       seg_skip;
  logic [15:0]       skip_dec;
  pix_fmt_e          ncomp_fmt;

  assign accept   = in_valid_i && in_ready_o;
  assign seg_len  = {hi_q, data_byte_i};
  assign seg_skip = seg_len - LenSelf;
  assign skip_dec = skip_q - 16'd1;

  always_comb begin
    case (data_byte_i)
      NcompRgb:  ncomp_fmt = FmtRgb8;
      NcompLuma: ncomp_fmt = FmtLuma8;
      default:   ncomp_fmt = FmtUnknown;
    endcase
  end

  // Per-byte phase walk. The result computed here is pushed into the output
  // queue at the same edge that accepts the byte.
  always_comb begin
    phase_step = phase_q;
    skip_d     = skip_q;
    hi_d       = hi_q;
    height_d   = height_q;
    width_d    = width_q;
    marker_d   = marker_q;
    sent_d     = sent_q;
    res_valid  = 1'b0;
    res        = '{header_ok: 1'b0, frame_found: 1'b0, image_width: 16'd0,
                   image_height: 16'd0, pixel_format: FmtUnknown};

    unique case (phase_q)
      PhSoi0: begin
        hi_d       = data_byte_i;
        phase_step = PhSoi1;
      end
      PhSoi1: begin
        if (hi_q == ByteFf && data_byte_i == ByteSoi) begin
          phase_step = PhPrefix;
        end else begin
          // Bad start-of-image: report right away, the rest of the file is ignored.
          res_valid  = 1'b1;
          sent_d     = 1'b1;
          phase_step = PhDone;
        end
      end
      PhPrefix: phase_step = PhCode;
      PhCode: begin
        marker_d   = data_byte_i;
        phase_step = PhLenHi;
      end
      PhLenHi: begin
        hi_d       = data_byte_i;
        phase_step = PhLenLo;
      end
      PhLenLo: begin
        if (marker_q == ByteSof0 || marker_q == ByteSof2) begin
          phase_step = PhPrec;
        end else begin
          // Lengths below two wrap to a long skip, as the 16-bit count does.
          skip_d     = seg_skip;
          phase_step = (seg_skip == 16'd0) ? PhPrefix : PhSkip;
        end
      end
      PhSkip: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_step = PhPrefix;
        end
      end
      PhPrec: phase_step = PhHHi;
      PhHHi: begin
        hi_d       = data_byte_i;
        phase_step = PhHLo;
      end
      PhHLo: begin
        height_d   = {hi_q, data_byte_i};
        phase_step = PhWHi;
      end
      PhWHi: begin
        hi_d       = data_byte_i;
        phase_step = PhWLo;
      end
      PhWLo: begin
        width_d    = {hi_q, data_byte_i};
        phase_step = PhNcomp;
      end
      PhNcomp: begin
        res_valid  = 1'b1;
        res        = '{header_ok: 1'b1, frame_found: 1'b1, image_width: width_q,
                       image_height: height_q, pixel_format: ncomp_fmt};
        sent_d     = 1'b1;
        phase_step = PhDone;
      end
      default: phase_step = PhDone;
    endcase

    phase_d = phase_step;
    if (stream_end_i) begin
      // A file that ends before any result still reports once, as not found.
      if (!res_valid && !sent_q) begin
        res_valid     = 1'b1;
        res.header_ok = (phase_step >= PhPrefix);
      end
      phase_d = PhSoi0;
      sent_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSoi0;
      sent_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      sent_q  <= sent_d;
    end
  end

  // Holds are always written before they are read within one file.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      skip_q   <= skip_d;
      hi_q     <= hi_d;
      height_q <= height_d;
      width_q  <= width_d;
      marker_q <= marker_d;
    end
  end

  jfhs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .room_o      (buf_room),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data)
  );

  assign in_ready_o     = buf_room;
  assign header_ok_o    = out_data.header_ok;
  assign frame_found_o  = out_data.frame_found;
  assign image_width_o  = out_data.image_width;
  assign image_height_o = out_data.image_height;
  assign pixel_format_o = out_data.pixel_format;

endmodule

>>> design/jfhs_checker.sv
`include "jpeg_frame_header_scanner_defines.svh"

module jfhs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        header_ok_o,
  input logic        frame_found_o,
  input logic [15:0] image_width_o,
  input logic [15:0] image_height_o,
  input logic [1:0]  pixel_format_o
);
  import jfhs_pkg::*;

  logic [35:0] payload;
  logic        no_size;

  assign payload = {header_ok_o, frame_found_o, image_width_o, image_height_o,
                    pixel_format_o};
  assign no_size = (image_width_o == 16'd0) && (image_height_o == 16'd0) &&
                   (pixel_format_o == FmtUnknown);

  // A result beat that is not taken stays up with the same payload.
  `JFHS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `JFHS_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(payload))

  // A frame can only be found behind a good start-of-image.
  `JFHS_ASSERT(a_found_has_soi, out_valid_o && frame_found_o |-> header_ok_o)

  // A not-found report carries no size and no format.
  `JFHS_ASSERT(a_not_found_zero, out_valid_o && !frame_found_o |-> no_size)

  // The format code never takes its unused value.
  `JFHS_ASSERT(a_fmt_range, out_valid_o |-> pixel_format_o <= FmtLuma8)

endmodule

bind jpeg_frame_header_scanner jfhs_checker u_jfhs_checker (.*);

>>> bench/tb.sv
module tb;
  import jfhs_pkg::*;

  // Own view of the parser walk. The order matters: every phase from SegPrefix
  // to SofComps means that both start-of-image bytes were seen and matched.
  typedef enum logic [3:0] {
    SoiFirst,
    SoiSecond,
    SegPrefix,
    SegCode,
    SegLenHi,
    SegLenLo,
    SegSkip,
    SofPrec,
    SofHeightHi,
    SofHeightLo,
    SofWidthHi,
    SofWidthLo,
    SofComps,
    ScanDone
  } walk_phase_e;

  // One byte beat waiting to be offered. wait_drain holds it back until every
  // expected header report has been received.
  typedef struct {
    logic [7:0] data;
    logic       ends;
    logic       wait_drain;
  } byte_beat_t;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned CalmTail   = 120;

  // Clock and reset. Every block input starts at a known value.
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        stream_end_i = 1'b0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        header_ok_o;
  logic        frame_found_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [1:0]  pixel_format_o;

  jpeg_frame_header_scanner u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .header_ok_o    (header_ok_o),
    .frame_found_o  (frame_found_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .pixel_format_o (pixel_format_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte beats still to be offered, and the header reports that the walk
  // below says the block owes us, oldest first.
  byte_beat_t  beats_to_send[$];
  result_t     owed_reports[$];

  // Shadow of the parser state.
  walk_phase_e walk_phase;
  logic [15:0] skip_left;
  logic [7:0]  pair_hi;
  logic [15:0] height_acc;
  logic [15:0] width_acc;
  logic [7:0]  marker_code;
  logic        answered;

  int unsigned mismatches      = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned reports_checked = 0;
  int unsigned files_made      = 0;
  int unsigned useful_bytes    = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  bit          calm            = 1'b0;
  bit          send_idles      = 1'b1;
  bit          take_idles      = 1'b1;

  task automatic reset_walk();
    walk_phase  = SoiFirst;
    skip_left   = '0;
    pair_hi     = '0;
    height_acc  = '0;
    width_acc   = '0;
    marker_code = '0;
    answered    = 1'b0;
  endtask

  // Advance the shadow parser by one accepted byte and queue the report that
  // this byte causes, if any.
  task automatic scan_byte(input logic [7:0] b, input logic ends);
    result_t rep;
    bit      emitted;
    rep     = '0;
    emitted = 1'b0;
    case (walk_phase)
      SoiFirst: begin
        pair_hi    = b;
        walk_phase = SoiSecond;
      end
      SoiSecond: begin
        if (pair_hi == ByteFf && b == ByteSoi) begin
          walk_phase = SegPrefix;
        end else begin
          // Bad start of image: the all-zero report goes out right here.
          emitted    = 1'b1;
          answered   = 1'b1;
          walk_phase = ScanDone;
        end
      end
      SegPrefix: walk_phase = SegCode;
      SegCode: begin
        marker_code = b;
        walk_phase  = SegLenHi;
      end
      SegLenHi: begin
        pair_hi    = b;
        walk_phase = SegLenLo;
      end
      SegLenLo: begin
        if (marker_code == ByteSof0 || marker_code == ByteSof2) begin
          // The frame header length is not used.
          walk_phase = SofPrec;
        end else begin
          // A length below two wraps to a very long skip.
          skip_left  = {pair_hi, b} - LenSelf;
          walk_phase = (skip_left == '0) ? SegPrefix : SegSkip;
        end
      end
      SegSkip: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == '0) walk_phase = SegPrefix;
      end
      SofPrec: walk_phase = SofHeightHi;
      SofHeightHi: begin
        pair_hi    = b;
        walk_phase = SofHeightLo;
      end
      SofHeightLo: begin
        height_acc = {pair_hi, b};
        walk_phase = SofWidthHi;
      end
      SofWidthHi: begin
        pair_hi    = b;
        walk_phase = SofWidthLo;
      end
      SofWidthLo: begin
        width_acc  = {pair_hi, b};
        walk_phase = SofComps;
      end
      SofComps: begin
        rep.header_ok    = 1'b1;
        rep.frame_found  = 1'b1;
        rep.image_width  = width_acc;
        rep.image_height = height_acc;
        rep.pixel_format = (b == NcompRgb) ? FmtRgb8 :
                           (b == NcompLuma) ? FmtLuma8 : FmtUnknown;
        emitted          = 1'b1;
        answered         = 1'b1;
        walk_phase       = ScanDone;
      end
      default: walk_phase = ScanDone;
    endcase
    if (ends) begin
      // A file that ends before any report still gets a not-found report.
      if (!emitted && !answered) begin
        rep.header_ok = (walk_phase != SoiFirst && walk_phase != SoiSecond);
        emitted       = 1'b1;
      end
      reset_walk();
    end
    if (emitted) owed_reports.push_back(rep);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch at report %0d: %s expected %0h got %0h",
               reports_checked, what, want, got);
    end
  endtask

  task automatic push_beat(input logic [7:0] b, input bit ends, input bit wait_drain);
    byte_beat_t nb;
    nb.data       = b;
    nb.ends       = ends;
    nb.wait_drain = wait_drain;
    beats_to_send.push_back(nb);
  endtask

  // Queues a byte string written as hex pairs; ends marks its last byte.
  task automatic push_hex(input string hex, input bit ends);
    int unsigned n;
    n = hex.len() / 2;
    for (int unsigned i = 0; i < n; i++) begin
      push_beat(8'(hex.substr(2 * i, 2 * i + 1).atohex()), ends && (i == n - 1), 1'b0);
    end
  endtask

  // Frame dimensions lean toward the extremes now and then.
  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  // One random file. Most are well formed: start of image, a few segments with
  // random content, then a frame header and some trailing bytes. The rest are
  // noise, bad starts of image, and files cut short at a random byte.
  task automatic add_scan_file(input bit wait_drain);
    logic [7:0]  body[$];
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] len;
    logic [15:0] dim;
    int unsigned kind;
    int unsigned result_at;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 20)) body.push_back(8'($urandom_range(0, 255)));
      result_at = body.size() - 1;
    end else if (kind < 12) begin
      hi = ($urandom_range(0, 1) == 0) ? ByteFf : 8'($urandom_range(0, 255));
      lo = ($urandom_range(0, 1) == 0) ? ByteSoi : 8'($urandom_range(0, 255));
      if (hi == ByteFf && lo == ByteSoi) lo = 8'hD9;
      body.push_back(hi);
      body.push_back(lo);
      result_at = 1;
    end else begin
      body.push_back(ByteFf);
      body.push_back(ByteSoi);
      repeat ($urandom_range(0, 2)) begin
        // Prefix byte is not checked, so it is sometimes not FF.
        body.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : ByteFf);
        hi = 8'($urandom_range(0, 255));
        if (hi == ByteSof0 || hi == ByteSof2) hi = hi ^ 8'h01;
        body.push_back(hi);
        len = ($urandom_range(0, 31) == 0) ? 16'($urandom_range(2, 100)) :
                                             16'($urandom_range(2, 8));
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        repeat (len - 2) body.push_back(8'($urandom_range(0, 255)));
      end
      body.push_back(ByteFf);
      body.push_back(($urandom_range(0, 1) == 0) ? ByteSof0 : ByteSof2);
      len = 16'($urandom_range(0, 65535));
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      body.push_back(8'($urandom_range(0, 255)));
      dim = pick_dim();
      body.push_back(dim[15:8]);
      body.push_back(dim[7:0]);
      dim = pick_dim();
      body.push_back(dim[15:8]);
      body.push_back(dim[7:0]);
      case ($urandom_range(0, 3))
        0, 1:    body.push_back(NcompRgb);
        2:       body.push_back(NcompLuma);
        default: body.push_back(8'($urandom_range(0, 255)));
      endcase
      result_at = body.size() - 1;
    end
    if (kind >= 5) repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
    cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, body.size() - 1) : body.size() - 1;
    for (int unsigned i = 0; i <= cut; i++) begin
      push_beat(body[i], i == cut, wait_drain && i == 0);
    end
    useful_bytes += ((cut < result_at) ? cut : result_at) + 1;
    files_made++;
  endtask

  // Sender. A new beat goes out whenever the slot is free and no idle gap or
  // drain wait holds it back; valid and payload stay put until the beat is taken.
  // The shadow parser advances on every accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    byte_beat_t nb;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= 8'h00;
      stream_end_i <= 1'b0;
      gap_left     <= 0;
      calm         <= 1'b0;
      send_idles   <= 1'b1;
    end else begin
      calm <= (beats_to_send.size() < CalmTail);
      if ($urandom_range(0, 63) == 0) send_idles <= !send_idles;
      if (in_valid_i && in_ready_o) begin
        scan_byte(data_byte_i, stream_end_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() == 0 ||
                     (beats_to_send[0].wait_drain && owed_reports.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          nb = beats_to_send.pop_front();
          in_valid_i   <= 1'b1;
          data_byte_i  <= nb.data;
          stream_end_i <= nb.ends;
          if (!calm && send_idles && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(1, 9);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own, so that two reports back up
  // inside the block and it has to stop taking bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_checked >= 20) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end
  end

  // Receiver with short random stall bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      take_idles  <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) take_idles <= !take_idles;
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && take_idles && $urandom_range(0, 5) == 0) begin
        stall_left  <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted report is checked field by field against the oldest one owed.
  always @(posedge clk_i) begin : check_reports
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_reports.size() == 0) begin
        report_mismatch("report with none owed, header_ok", 0, 32'(header_ok_o));
      end else begin
        want = owed_reports.pop_front();
        if (header_ok_o !== want.header_ok)
          report_mismatch("header_ok", 32'(want.header_ok), 32'(header_ok_o));
        if (frame_found_o !== want.frame_found)
          report_mismatch("frame_found", 32'(want.frame_found), 32'(frame_found_o));
        if (image_width_o !== want.image_width)
          report_mismatch("image_width", 32'(want.image_width), 32'(image_width_o));
        if (image_height_o !== want.image_height)
          report_mismatch("image_height", 32'(want.image_height), 32'(image_height_o));
        if (pixel_format_o !== want.pixel_format)
          report_mismatch("pixel_format", 32'(want.pixel_format), 32'(pixel_format_o));
      end
      reports_checked++;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("watchdog expired after %0d idle cycles", quiet_cycles);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    bit drain_marked;
    drain_marked = 1'b0;
    reset_walk();

    // Directed files. Bad start of image, then files that end on the first
    // and on the second byte.
    push_hex("FFD7", 1'b1);
    push_hex("00", 1'b1);
    push_hex("FFD8", 1'b1);
    // Length of exactly two, then SOF0 with height FFFF, width 0, three
    // components, and trailing bytes that must be ignored.
    push_hex("FFD8FFE00002FFC0001108FFFF000003AA55", 1'b1);
    // SOF2 behind a prefix that is not FF, one component, width FFFF.
    push_hex("FFD800C2FFFF080001FFFF01", 1'b1);
    // File that ends in the middle of the frame header.
    push_hex("FFD8FFC000110812", 1'b1);
    // Skipped bytes that look like markers, then an unknown component count.
    push_hex("FFD8FFDB0005FFC0C2FFC2000B0800100020FF", 1'b1);
    // Length of one wraps to a skip of 65535 bytes; the file ends well inside
    // it, so a frame header pattern there is not seen.
    push_hex("FFD8FFE10001", 1'b0);
    repeat (10) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    push_hex("FFC0001108ABCD1234", 1'b0);
    push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);

    // Random files. Somewhere in the middle the sender waits for all reports.
    while (useful_bytes < 1000 || files_made < 60) begin
      add_scan_file(!drain_marked && useful_bytes >= 500);
      if (useful_bytes >= 500) drain_marked = 1'b1;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_to_send.size() != 0 || in_valid_i || owed_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("Scanned %0d random files plus directed ones: %0d byte beats, %0d reports.",
             files_made, bytes_accepted, reports_checked);
    $display("Covered bad and cut-short headers, segment skips with wrap, SOF0 and SOF2.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/jfhs_pkg.sv
design/jfhs_out_buf.sv
design/jpeg_frame_header_scanner.sv
design/jfhs_checker.sv
bench/tb.sv
